// ----- sv/assert_macros.svh -----
// assertion macros used by the deque rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define CDQ_ASSERT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cdq assertion failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define CDQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cdq assertion failed");

`endif

// ----- sv/cdq_pkg.sv -----
// constants, request and status codes, and ring index and fill helpers for the deque
package cdq_pkg;

    localparam int DEPTH  = 16;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam int DATA_W = 32;
    localparam int REQ_W  = 3;
    localparam int FILL_W = 5;
    localparam int STAT_W = 2;

    localparam logic [REQ_W-1:0] REQ_PUSH_HEAD = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_TAIL = 3'd1;
    localparam logic [REQ_W-1:0] REQ_POP_HEAD  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_TAIL  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_SEARCH    = 3'd4;
    localparam logic [REQ_W-1:0] REQ_REVERSE   = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // base + off modulo DEPTH, valid for base < DEPTH and off <= DEPTH
    function automatic logic [ADDR_W-1:0] wrap_idx(input logic [ADDR_W-1:0] base,
                                                   input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= SUM_W'(DEPTH))
        begin
            sum = sum - SUM_W'(DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

    function automatic logic [FILL_W-1:0] fill_of(input logic [CNT_W-1:0] cnt);
        logic [CNT_W+FILL_W-1:0] ext;
        ext = {{FILL_W{1'b0}}, cnt};
        return ext[FILL_W-1:0];
    endfunction

endpackage

// ----- sv/cdq_ram.sv -----
// single write port, single registered read port ring storage
module cdq_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/circular_deque_with_search.sv -----
// bounded double-ended queue on a ring store with sequential search
//
//  channel  direction  handshake            fields
//  in       to block   in_valid / in_stall  req_type, value
//  out      from block out_valid / out_stall data, found, fill_count, status
//
// one request at a time, its input freed on return to idle; a push, reverse or rejected
// request passes the execute and done states, a pop adds a read state, and a search a read
// and compare state per entry visited, on the single storage read port and one shared comparator.
// the result sits in an output register, so a new request is taken while it waits.
// reset clears head, count, direction and control; storage contents are not cleared.
// out_stall holds the finished result and can back up the input; in_stall is high while a request is in work.
module circular_deque_with_search (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [cdq_pkg::REQ_W-1:0]    req_type,
    input  logic signed [cdq_pkg::DATA_W-1:0] value,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [cdq_pkg::DATA_W-1:0] data,
    output logic                         found,
    output logic [cdq_pkg::FILL_W-1:0]   fill_count,
    output logic [cdq_pkg::STAT_W-1:0]   status
);
    import cdq_pkg::*;

    `include "assert_macros.svh"

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_EXEC     = 6'b000010,
        S_POP      = 6'b000100,
        S_SCAN_RD  = 6'b001000,
        S_SCAN_CMP = 6'b010000,
        S_DONE     = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    logic [REQ_W-1:0]    req_reg, req_next;
    logic [DATA_W-1:0]   val_reg, val_next;
    logic [ADDR_W-1:0]   head_reg, head_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                rev_reg, rev_next;
    logic [ADDR_W-1:0]   k_reg, k_next;
    logic [DATA_W-1:0]   res_data_reg, res_data_next;
    logic                res_found_reg, res_found_next;
    logic [STAT_W-1:0]   res_status_reg, res_status_next;
    logic                out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]   data_reg, data_next;
    logic                found_reg, found_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [STAT_W-1:0]   status_reg, status_next;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [DATA_W-1:0]   ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [DATA_W-1:0]   ram_rdata;

    logic                at_front;
    logic                load_out;
    logic                is_full;
    logic                is_empty;
    logic                hit;

    cdq_ram #(
        .DEPTH (DEPTH),
        .WIDTH (DATA_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign at_front = ((req_reg == REQ_PUSH_HEAD) || (req_reg == REQ_POP_HEAD)) ^ rev_reg;
    assign is_full  = (cnt_reg == CNT_W'(DEPTH));
    assign is_empty = (cnt_reg == '0);
    assign hit      = (ram_rdata == val_reg);
    assign load_out = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);
    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        val_next        = val_reg;
        head_next       = head_reg;
        cnt_next        = cnt_reg;
        rev_next        = rev_reg;
        k_next          = k_reg;
        res_data_next   = res_data_reg;
        res_found_next  = res_found_reg;
        res_status_next = res_status_reg;
        ram_we          = 1'b0;
        ram_waddr       = head_reg;
        ram_wdata       = val_reg;
        ram_raddr       = head_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next        = req_type;
                    val_next        = value;
                    res_data_next   = '0;
                    res_found_next  = 1'b0;
                    res_status_next = ST_OK;
                    state_next      = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_DONE;
                unique case (req_reg)
                    REQ_PUSH_HEAD, REQ_PUSH_TAIL:
                    begin
                        if (is_full)
                        begin
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            ram_we   = 1'b1;
                            cnt_next = cnt_reg + 1'b1;
                            if (at_front)
                            begin
                                ram_waddr = wrap_idx(head_reg, CNT_W'(DEPTH - 1));
                                head_next = ram_waddr;
                            end
                            else
                            begin
                                ram_waddr = wrap_idx(head_reg, cnt_reg);
                            end
                        end
                    end
                    REQ_POP_HEAD, REQ_POP_TAIL:
                    begin
                        if (is_empty)
                        begin
                            res_status_next = ST_EMPTY;
                        end
                        else
                        begin
                            cnt_next   = cnt_reg - 1'b1;
                            state_next = S_POP;
                            if (at_front)
                            begin
                                ram_raddr = head_reg;
                                head_next = wrap_idx(head_reg, CNT_W'(1));
                            end
                            else
                            begin
                                ram_raddr = wrap_idx(head_reg, cnt_reg - 1'b1);
                            end
                        end
                    end
                    REQ_SEARCH:
                    begin
                        if (!is_empty)
                        begin
                            k_next     = '0;
                            state_next = S_SCAN_RD;
                        end
                    end
                    REQ_REVERSE:
                    begin
                        rev_next = ~rev_reg;
                    end
                    default:
                    begin
                        res_status_next = ST_OK;
                    end
                endcase
            end
            S_POP:
            begin
                res_data_next = ram_rdata;
                state_next    = S_DONE;
            end
            S_SCAN_RD:
            begin
                ram_raddr  = wrap_idx(head_reg, CNT_W'(k_reg));
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                priority if (hit)
                begin
                    res_found_next = 1'b1;
                    state_next     = S_DONE;
                end
                else if ((CNT_W'(k_reg) + CNT_W'(1)) == cnt_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_SCAN_RD;
                end
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        data_next      = data_reg;
        found_next     = found_reg;
        fill_next      = fill_reg;
        status_next    = status_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            data_next      = res_data_reg;
            found_next     = res_found_reg;
            fill_next      = fill_of(cnt_reg);
            status_next    = res_status_reg;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            cnt_reg       <= '0;
            rev_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            cnt_reg       <= cnt_next;
            rev_reg       <= rev_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        val_reg        <= val_next;
        k_reg          <= k_next;
        res_data_reg   <= res_data_next;
        res_found_reg  <= res_found_next;
        res_status_reg <= res_status_next;
        data_reg       <= data_next;
        found_reg      <= found_next;
        fill_reg       <= fill_next;
        status_reg     <= status_next;
    end

    assign out_valid  = out_valid_reg;
    assign data       = data_reg;
    assign found      = found_reg;
    assign fill_count = fill_reg;
    assign status     = status_reg;

    `CDQ_ASSERT(a_cnt_max, 1'b1, cnt_reg <= CNT_W'(DEPTH))
    `CDQ_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, state_reg == S_EXEC)
    `CDQ_ASSERT(a_full_status, load_out && (res_status_reg == ST_FULL), is_full)
    `CDQ_ASSERT(a_pop_dec, state_reg == S_POP, cnt_reg == $past(cnt_reg) - 1'b1)
    `CDQ_ASSERT(a_scan_nonempty, (state_reg == S_SCAN_RD) || (state_reg == S_SCAN_CMP), !is_empty)

endmodule

// ----- tb/sv/tb_circular_deque_with_search.sv -----
// testbench for the ring-buffer deque with search: directed table, random phases, predictor
`timescale 1ns / 100ps

module tb_circular_deque_with_search;

    import cdq_pkg::*;

    localparam logic [REQ_W-1:0] REQ_NOP_LO  = 3'd6;
    localparam logic [REQ_W-1:0] REQ_NOP_HI  = 3'd7;
    localparam int ITEMS_PER_PHASE = 375;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_CYCLES    = 2 * DEPTH + 8;
    localparam int CYCLE_LIMIT     = 500000;

    typedef struct {
        logic signed [DATA_W-1:0] data;
        logic                     found;
        logic [FILL_W-1:0]        fill;
        logic [STAT_W-1:0]        status;
    } deque_response_t;

    typedef struct {
        logic [REQ_W-1:0]         req;
        logic signed [DATA_W-1:0] value;
        bit                       typed;
        deque_response_t          resp;
    } stim_row_t;

    logic                     clk;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [REQ_W-1:0]         req_type = '0;
    logic signed [DATA_W-1:0] value = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [DATA_W-1:0] data;
    logic                     found;
    logic [FILL_W-1:0]        fill_count;
    logic [STAT_W-1:0]        status;

    logic [DATA_W-1:0] ring [DEPTH];
    int unsigned       ring_head = 0;
    int unsigned       ring_count = 0;
    bit                ring_reversed = 1'b0;

    deque_response_t pending_responses [$];
    stim_row_t       stim_rows [$];
    int              error_count = 0;
    int              cycle_count = 0;
    int              send_pct = 0;
    int              stall_pct = 0;
    logic            hold_trigger = 1'b0;
    logic            hold_output = 1'b0;

    circular_deque_with_search dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .value      (value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .data       (data),
        .found      (found),
        .fill_count (fill_count),
        .status     (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic deque_response_t apply_request(input logic [REQ_W-1:0] req,
                                                      input logic [DATA_W-1:0] val);
        deque_response_t r;
        bit              at_front;
        int unsigned     k;
        r.data   = '0;
        r.found  = 1'b0;
        r.status = ST_OK;
        case (req)
            REQ_PUSH_HEAD, REQ_PUSH_TAIL:
            begin
                if (ring_count >= DEPTH)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    at_front = (req == REQ_PUSH_HEAD) ^ ring_reversed;
                    if (at_front)
                    begin
                        ring_head = (ring_head + DEPTH - 1) % DEPTH;
                        ring[ring_head] = val;
                    end
                    else
                    begin
                        ring[(ring_head + ring_count) % DEPTH] = val;
                    end
                    ring_count++;
                end
            end
            REQ_POP_HEAD, REQ_POP_TAIL:
            begin
                if (ring_count == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    at_front = (req == REQ_POP_HEAD) ^ ring_reversed;
                    if (at_front)
                    begin
                        r.data = ring[ring_head];
                        ring_head = (ring_head + 1) % DEPTH;
                    end
                    else
                    begin
                        r.data = ring[(ring_head + ring_count - 1) % DEPTH];
                    end
                    ring_count--;
                end
            end
            REQ_SEARCH:
            begin
                for (k = 0; k < ring_count; k++)
                begin
                    if (ring[(ring_head + k) % DEPTH] == val)
                    begin
                        r.found = 1'b1;
                    end
                end
            end
            REQ_REVERSE:
            begin
                ring_reversed = ~ring_reversed;
            end
            default:
            begin
            end
        endcase
        r.fill = FILL_W'(ring_count);
        return r;
    endfunction

    function automatic void add_row(input logic [REQ_W-1:0] req,
                                    input logic signed [DATA_W-1:0] val,
                                    input bit typed,
                                    input logic signed [DATA_W-1:0] exp_data,
                                    input logic exp_found,
                                    input logic [FILL_W-1:0] exp_fill,
                                    input logic [STAT_W-1:0] exp_status);
        stim_row_t row;
        row.req         = req;
        row.value       = val;
        row.typed       = typed;
        row.resp.data   = exp_data;
        row.resp.found  = exp_found;
        row.resp.fill   = exp_fill;
        row.resp.status = exp_status;
        stim_rows.push_back(row);
    endfunction

    function automatic logic [REQ_W-1:0] pick_request(input bit filling);
        int r;
        r = $urandom_range(99);
        if (r < 3)
        begin
            return REQ_W'($urandom_range(REQ_NOP_HI, REQ_NOP_LO));
        end
        if (r < 10)
        begin
            return REQ_REVERSE;
        end
        if (r < 25)
        begin
            return REQ_SEARCH;
        end
        if (r < (filling ? 80 : 45))
        begin
            return $urandom_range(1) ? REQ_PUSH_TAIL : REQ_PUSH_HEAD;
        end
        return $urandom_range(1) ? REQ_POP_TAIL : REQ_POP_HEAD;
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value(input logic [REQ_W-1:0] req);
        int r;
        r = $urandom_range(99);
        if (req == REQ_SEARCH && ring_count > 0 && r < 50)
        begin
            return ring[(ring_head + $urandom_range(ring_count - 1)) % DEPTH];
        end
        if (r < 20)
        begin
            case ($urandom_range(3))
                0: return 32'sh7fffffff;
                1: return 32'sh80000000;
                2: return -1;
                default: return 0;
            endcase
        end
        if (r < 45)
        begin
            return $urandom_range(7);
        end
        return $urandom;
    endfunction

    task automatic offer_request(input logic [REQ_W-1:0] req,
                                 input logic signed [DATA_W-1:0] val,
                                 input bit typed,
                                 input deque_response_t typed_resp);
        deque_response_t resp;
        while ($urandom_range(99) < send_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req;
        value    <= val;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        resp = apply_request(req, val);
        pending_responses.push_back(typed ? typed_resp : resp);
    endtask

    // receiver: check each accepted result, then choose the stall for the next cycle
    always @(posedge clk)
    begin : check_results
        deque_response_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_responses.size() == 0)
            begin
                $error("unexpected result: data %0d fill_count %0d status %0d",
                       data, fill_count, status);
                error_count++;
            end
            else
            begin
                want = pending_responses.pop_front();
                if (data !== want.data)
                begin
                    $error("data: expected %0d, got %0d", want.data, data);
                    error_count++;
                end
                if (found !== want.found)
                begin
                    $error("found: expected %0d, got %0d", want.found, found);
                    error_count++;
                end
                if (fill_count !== want.fill)
                begin
                    $error("fill_count: expected %0d, got %0d", want.fill, fill_count);
                    error_count++;
                end
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    error_count++;
                end
            end
        end
        out_stall <= hold_output || ($urandom_range(99) < stall_pct);
    end

    // long receiver hold-off so the block backs up onto its input
    initial
    begin
        wait (hold_trigger);
        @(posedge clk);
        hold_output <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_output <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin : stimulus
        int                       i;
        int                       phase;
        int                       n;
        bit                       filling;
        logic [REQ_W-1:0]         req;
        logic signed [DATA_W-1:0] val;
        deque_response_t          no_resp;

        filling = 1'b0;
        no_resp.data   = '0;
        no_resp.found  = 1'b0;
        no_resp.fill   = '0;
        no_resp.status = ST_OK;

        // empty store, direction toggle and an unused code
        add_row(REQ_POP_HEAD, 0, 1'b1, 0, 1'b0, 0, ST_EMPTY);
        add_row(REQ_POP_TAIL, 0, 1'b1, 0, 1'b0, 0, ST_EMPTY);
        add_row(REQ_SEARCH, 0, 1'b1, 0, 1'b0, 0, ST_OK);
        add_row(REQ_REVERSE, 0, 1'b1, 0, 1'b0, 0, ST_OK);
        add_row(REQ_NOP_LO, -1, 1'b1, 0, 1'b0, 0, ST_OK);
        // fill to capacity from both ends while reversed
        for (i = 0; i < DEPTH; i++)
        begin
            case (i)
                0: val = 32'sh7fffffff;
                1: val = 32'sh80000000;
                2: val = -1;
                3: val = 0;
                default: val = $urandom;
            endcase
            add_row((i % 2) ? REQ_PUSH_TAIL : REQ_PUSH_HEAD, val, 1'b1, 0, 1'b0,
                    FILL_W'(i + 1), ST_OK);
        end
        add_row(REQ_PUSH_HEAD, 12345, 1'b1, 0, 1'b0, FILL_W'(DEPTH), ST_FULL);
        add_row(REQ_SEARCH, 32'sh80000000, 1'b0, 0, 1'b0, 0, ST_OK);
        add_row(REQ_REVERSE, 0, 1'b0, 0, 1'b0, 0, ST_OK);
        add_row(REQ_POP_HEAD, 0, 1'b0, 0, 1'b0, 0, ST_OK);
        add_row(REQ_POP_TAIL, 0, 1'b0, 0, 1'b0, 0, ST_OK);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_rows[i])
        begin
            offer_request(stim_rows[i].req, stim_rows[i].value, stim_rows[i].typed,
                          stim_rows[i].resp);
        end

        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_pct = 0;
                    stall_pct <= 0;
                end
                1:
                begin
                    send_pct = 73;
                    stall_pct <= 0;
                end
                2:
                begin
                    send_pct = 0;
                    stall_pct <= 73;
                end
                default:
                begin
                    send_pct = 18;
                    stall_pct <= 18;
                end
            endcase
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (n % 48 == 0)
                begin
                    filling = ~filling;
                end
                if (phase == 0 && n == 100)
                begin
                    hold_trigger <= 1'b1;
                end
                req = pick_request(filling);
                val = pick_value(req);
                offer_request(req, val, 1'b0, no_resp);
            end
        end
        in_valid <= 1'b0;

        while (pending_responses.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
